FILE: rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, types and codes for the point-to-segment projection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  localparam int COORD_W       = 24;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int DIST_W        = 25;
  localparam int ROOT_STEPS    = SUM_W / 2;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic        [SUM_W-1:0]   usum_t;
  typedef logic signed [SUM_W-1:0]   ssum_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } dvec_t;

  typedef enum logic [1:0] {
    RGN_INTERIOR = 2'd0,
    RGN_AT_A     = 2'd1,
    RGN_AT_B     = 2'd2
  } region_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_X = 3'd0,
    CFG_A_Y = 3'd1,
    CFG_A_Z = 3'd2,
    CFG_B_X = 3'd3,
    CFG_B_Y = 3'd4,
    CFG_B_Z = 3'd5
  } cfg_idx_t;

  // sign extension of a coordinate by one bit
  function automatic diff_t sx(input coord_t v);
    return {v[COORD_W-1], v};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/psd_if.sv
// ----------------------------------------------------------------------------
// psd channel interfaces
// Valid/ready channels for query points in and projection results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface psd_in_if import psd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;

  modport source(output valid, output point_x, output point_y, output point_z,
                 input ready);
  modport sink(input valid, input point_x, input point_y, input point_z,
               output ready);
endinterface

interface psd_out_if import psd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
  logic              valid;
  logic              ready;
  coord_t            near_x;
  coord_t            near_y;
  coord_t            near_z;
  logic [FRAC_BITS:0] fraction;
  logic [1:0]        region;
  logic [DIST_W-1:0] distance;

  modport source(output valid, output near_x, output near_y, output near_z,
                 output fraction, output region, output distance, input ready);
  modport sink(input valid, input near_x, input near_y, input near_z,
               input fraction, input region, input distance, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Offsets, products and sums: squared length and dot product, three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_front import psd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  vec_t  pnt,
  input  vec_t  a_pt,
  input  dvec_t seg_d,
  output logic  out_vld,
  output vec_t  out_pnt,
  output usum_t out_len2,
  output ssum_t out_dot
);

  logic [2:0] vld_r;
  vec_t       p1_r, p2_r, p3_r;
  dvec_t      w1_r;
  prod_t      dd_r [3];
  prod_t      dw_r [3];
  usum_t      len2_r;
  ssum_t      dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= pnt;
      w1_r.x <= sx(pnt.x) - sx(a_pt.x);
      w1_r.y <= sx(pnt.y) - sx(a_pt.y);
      w1_r.z <= sx(pnt.z) - sx(a_pt.z);

      p2_r    <= p1_r;
      dd_r[0] <= seg_d.x * seg_d.x;
      dd_r[1] <= seg_d.y * seg_d.y;
      dd_r[2] <= seg_d.z * seg_d.z;
      dw_r[0] <= seg_d.x * w1_r.x;
      dw_r[1] <= seg_d.y * w1_r.y;
      dw_r[2] <= seg_d.z * w1_r.z;

      p3_r   <= p2_r;
      len2_r <= usum_t'(SUM_W'(dd_r[0]) + SUM_W'(dd_r[1]) + SUM_W'(dd_r[2]));
      dot_r  <= SUM_W'(dw_r[0]) + SUM_W'(dw_r[1]) + SUM_W'(dw_r[2]);
    end
  end

  assign out_vld  = vld_r[2];
  assign out_pnt  = p3_r;
  assign out_len2 = len2_r;
  assign out_dot  = dot_r;

endmodule

`default_nettype wire

FILE: rtl/core/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Clamp classification and restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_div import psd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  vec_t               pnt,
  input  usum_t              len2,
  input  ssum_t              dot,
  output logic               out_vld,
  output vec_t               out_pnt,
  output region_t            out_rgn,
  output logic [FRAC_BITS:0] out_t
);

  localparam int NS = FRAC_BITS + 1;

  logic [NS-1:0]        vld_r;
  vec_t                 pnt_r [NS];
  region_t              rgn_r [NS];
  usum_t                rem_r [NS];
  usum_t                len_r [NS];
  logic [FRAC_BITS-1:0] q_r   [NS];
  region_t              rgn_nxt;

  always_comb begin
    if (len2 == '0 || dot[SUM_W-1] || dot == '0) begin
      rgn_nxt = RGN_AT_A;
    end else if (usum_t'(dot) >= len2) begin
      rgn_nxt = RGN_AT_B;
    end else begin
      rgn_nxt = RGN_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pnt_r[0] <= pnt;
      rgn_r[0] <= rgn_nxt;
      rem_r[0] <= usum_t'(dot);
      len_r[0] <= len2;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [SUM_W:0] shl;
    logic           ge;

    assign shl = {rem_r[k-1], 1'b0};
    assign ge  = shl >= {1'b0, len_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        pnt_r[k] <= pnt_r[k-1];
        rgn_r[k] <= rgn_r[k-1];
        len_r[k] <= len_r[k-1];
        rem_r[k] <= ge ? SUM_W'(shl - {1'b0, len_r[k-1]}) : SUM_W'(shl);
        q_r[k]   <= {q_r[k-1][FRAC_BITS-2:0], ge};
      end
    end
  end

  always_comb begin
    case (rgn_r[NS-1])
      RGN_INTERIOR: out_t = {1'b0, q_r[NS-1]};
      RGN_AT_B:     out_t = (FRAC_BITS+1)'(1) << FRAC_BITS;
      default:      out_t = '0;
    endcase
  end

  assign out_vld = vld_r[NS-1];
  assign out_pnt = pnt_r[NS-1];
  assign out_rgn = rgn_r[NS-1];

endmodule

`default_nettype wire

FILE: rtl/core/psd_near.sv
// ----------------------------------------------------------------------------
// psd_near
// Interpolated closest point and squared distance, four stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_near import psd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  vec_t               pnt,
  input  region_t            rgn,
  input  logic [FRAC_BITS:0] t_in,
  input  vec_t               a_pt,
  input  vec_t               b_pt,
  input  dvec_t              seg_d,
  output logic               out_vld,
  output vec_t               out_near,
  output region_t            out_rgn,
  output logic [FRAC_BITS:0] out_t,
  output usum_t              out_dist2
);

  localparam int MW = DIFF_W + FRAC_BITS + 2;

  logic [3:0]         vld_r;
  vec_t               p1_r, p2_r;
  region_t            r1_r, r2_r, r3_r, r4_r;
  logic [FRAC_BITS:0] t1_r, t2_r, t3_r, t4_r;
  logic signed [MW-1:0] prod_r [3];
  vec_t               n2_r, n3_r, n4_r;
  prod_t              sq_r [3];
  usum_t              d2_r;
  logic signed [FRAC_BITS+1:0] t_s;

  function automatic coord_t sat(input logic signed [MW-1:0] v);
    if (v[MW-1:COORD_W-1] == '0 || v[MW-1:COORD_W-1] == '1) begin
      return v[COORD_W-1:0];
    end else if (v[MW-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  function automatic coord_t interp(input coord_t a, input coord_t b,
                                    input logic signed [MW-1:0] p, input region_t r);
    case (r)
      RGN_AT_A: return a;
      RGN_AT_B: return b;
      default:  return sat(MW'(a) + (p >>> FRAC_BITS));
    endcase
  endfunction

  assign t_s = $signed({1'b0, t_in});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r      <= pnt;
      r1_r      <= rgn;
      t1_r      <= t_in;
      prod_r[0] <= seg_d.x * t_s;
      prod_r[1] <= seg_d.y * t_s;
      prod_r[2] <= seg_d.z * t_s;

      p2_r   <= p1_r;
      r2_r   <= r1_r;
      t2_r   <= t1_r;
      n2_r.x <= interp(a_pt.x, b_pt.x, prod_r[0], r1_r);
      n2_r.y <= interp(a_pt.y, b_pt.y, prod_r[1], r1_r);
      n2_r.z <= interp(a_pt.z, b_pt.z, prod_r[2], r1_r);

      r3_r    <= r2_r;
      t3_r    <= t2_r;
      n3_r    <= n2_r;
      sq_r[0] <= (sx(p2_r.x) - sx(n2_r.x)) * (sx(p2_r.x) - sx(n2_r.x));
      sq_r[1] <= (sx(p2_r.y) - sx(n2_r.y)) * (sx(p2_r.y) - sx(n2_r.y));
      sq_r[2] <= (sx(p2_r.z) - sx(n2_r.z)) * (sx(p2_r.z) - sx(n2_r.z));

      r4_r <= r3_r;
      t4_r <= t3_r;
      n4_r <= n3_r;
      d2_r <= usum_t'(SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]));
    end
  end

  assign out_vld   = vld_r[3];
  assign out_near  = n4_r;
  assign out_rgn   = r4_r;
  assign out_t     = t4_r;
  assign out_dist2 = d2_r;

endmodule

`default_nettype wire

FILE: rtl/core/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined integer square root, one result bit per stage, saturating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_sqrt import psd_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  usum_t             rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [DIST_W-1:0] out_root,
  output logic [SIDE_W-1:0] side_out
);

  logic [ROOT_STEPS-1:0] vld_r;
  usum_t                 n_r    [ROOT_STEPS];
  usum_t                 res_r  [ROOT_STEPS];
  logic [SIDE_W-1:0]     side_r [ROOT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROOT_STEPS-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam usum_t BIT = usum_t'(1) << (SUM_W - 2 - 2 * k);
    usum_t             n_in, res_in, trial;
    logic [SIDE_W-1:0] s_in;

    if (k == 0) begin : g_first
      assign n_in   = rad;
      assign res_in = '0;
      assign s_in   = side_in;
    end else begin : g_next
      assign n_in   = n_r[k-1];
      assign res_in = res_r[k-1];
      assign s_in   = side_r[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= s_in;
        if (n_in >= trial) begin
          n_r[k]   <= n_in - trial;
          res_r[k] <= (res_in >> 1) + BIT;
        end else begin
          n_r[k]   <= n_in;
          res_r[k] <= res_in >> 1;
        end
      end
    end
  end

  assign out_vld  = vld_r[ROOT_STEPS-1];
  assign side_out = side_r[ROOT_STEPS-1];
  assign out_root = (|res_r[ROOT_STEPS-1][SUM_W-1:DIST_W]) ? '1
                                                           : res_r[ROOT_STEPS-1][DIST_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/point_segment_projection_distance_core.sv
// ----------------------------------------------------------------------------
// point_segment_projection_distance_core
// Closest point on a 3D segment A-B to a streamed query point, with distance.
// ----------------------------------------------------------------------------
// Use: write the endpoints A and B (signed Q16.8) through the cfg_ port while
//   no word is in flight, then stream query points on in_ch. Each input word
//   gives one output word on out_ch: the closest point, clamped t in Q1.16,
//   the clamp region and the truncated Euclidean distance in unsigned Q17.8.
// Throughput: one word per cycle unless stalled. Every stage is registered and
//   a word enters each cycle that the pipeline is not frozen.
// Pipeline: FRAC_BITS + 35 register stages from in_ch to out_ch.valid:
//   3 front stages for offsets, products and sums,
//   1 classify stage plus FRAC_BITS divider stages (one quotient bit each),
//   4 stages for interpolation and squared distance, 26 root stages (one
//   result bit each) and the output register.
// Stall: an output register plus a one-word skid stage. When the receiver
//   holds ready low the next finished word goes into the skid stage; only
//   then does in_ch.ready drop and the whole pipeline freeze in place.
// Reset: synchronous, active low. Clears all valid bits, the output and
//   skid flags and the endpoint registers (A = B = 0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_segment_projection_distance_core import psd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  psd_in_if.sink               in_ch,
  psd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  localparam int SIDE_W = $bits(vec_t) + FRAC_BITS + 1 + $bits(region_t);

  typedef struct packed {
    vec_t               near;
    logic [FRAC_BITS:0] frac;
    region_t            rgn;
    logic [DIST_W-1:0]  distance;
  } res_t;

  // endpoint registers
  vec_t  a_r, b_r;
  dvec_t seg_d;

  // pipeline hand-offs
  logic               en;
  vec_t               pnt_in;
  logic               f_vld, d_vld, n_vld, s_vld;
  vec_t               f_pnt, d_pnt, n_near;
  usum_t              f_len2, n_dist2;
  ssum_t              f_dot;
  region_t            d_rgn, n_rgn;
  logic [FRAC_BITS:0] d_t, n_t;
  logic [SIDE_W-1:0]  s_side;
  logic [DIST_W-1:0]  s_root;
  res_t               pipe_res;

  // output side
  logic out_vld_r, skid_vld_r;
  res_t out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_A_X: a_r.x <= cfg_wdata;
        CFG_A_Y: a_r.y <= cfg_wdata;
        CFG_A_Z: a_r.z <= cfg_wdata;
        CFG_B_X: b_r.x <= cfg_wdata;
        CFG_B_Y: b_r.y <= cfg_wdata;
        CFG_B_Z: b_r.z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // segment direction; the user keeps it static while words are in flight, the block does not enforce it
  assign seg_d.x = sx(b_r.x) - sx(a_r.x);
  assign seg_d.y = sx(b_r.y) - sx(a_r.y);
  assign seg_d.z = sx(b_r.z) - sx(a_r.z);

  // pipeline runs unless the skid stage is holding a word
  assign en          = !skid_vld_r;
  assign in_ch.ready = en;
  assign pnt_in      = '{x: in_ch.point_x, y: in_ch.point_y, z: in_ch.point_z};

  psd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_ch.valid),
    .pnt      (pnt_in),
    .a_pt     (a_r),
    .seg_d    (seg_d),
    .out_vld  (f_vld),
    .out_pnt  (f_pnt),
    .out_len2 (f_len2),
    .out_dot  (f_dot)
  );

  psd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f_vld),
    .pnt     (f_pnt),
    .len2    (f_len2),
    .dot     (f_dot),
    .out_vld (d_vld),
    .out_pnt (d_pnt),
    .out_rgn (d_rgn),
    .out_t   (d_t)
  );

  psd_near #(.FRAC_BITS(FRAC_BITS)) u_near (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (d_vld),
    .pnt       (d_pnt),
    .rgn       (d_rgn),
    .t_in      (d_t),
    .a_pt      (a_r),
    .b_pt      (b_r),
    .seg_d     (seg_d),
    .out_vld   (n_vld),
    .out_near  (n_near),
    .out_rgn   (n_rgn),
    .out_t     (n_t),
    .out_dist2 (n_dist2)
  );

  psd_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (n_vld),
    .rad      (n_dist2),
    .side_in  ({n_near, n_t, n_rgn}),
    .out_vld  (s_vld),
    .out_root (s_root),
    .side_out (s_side)
  );

  assign pipe_res = {s_side, s_root};

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_ch.ready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (s_vld) begin
      if (!out_vld_r || out_ch.ready) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_ch.ready) begin
        out_r <= skid_r;
      end
    end else if (s_vld) begin
      if (!out_vld_r || out_ch.ready) begin
        out_r <= pipe_res;
      end else begin
        skid_r <= pipe_res;
      end
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.near_x   = out_r.near.x;
  assign out_ch.near_y   = out_r.near.y;
  assign out_ch.near_z   = out_r.near.z;
  assign out_ch.fraction = out_r.frac;
  assign out_ch.region   = out_r.rgn;
  assign out_ch.distance = out_r.distance;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the point-to-segment projection core. A predictor
// computes each expected word from the current endpoints. A checker compares
// every result word field by field, in order. Both channel sides idle at
// random, and a watchdog ends the run if the handshakes stop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import psd_pkg::*;

  localparam int FRAC_BITS  = FRAC_BITS_DEF;
  localparam int LATENCY    = FRAC_BITS + 35;
  localparam int STALL_LIMIT = 5000;   // cycles with no word moving on either side

  typedef struct packed {
    coord_t             near_x;
    coord_t             near_y;
    coord_t             near_z;
    logic [FRAC_BITS:0] fraction;
    region_t            region;
    logic [DIST_W-1:0]  distance;
  } projection_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_wdata;

  psd_in_if in_ch ();
  psd_out_if #(.FRAC_BITS(FRAC_BITS)) out_ch ();

  point_segment_projection_distance_core #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // bench copy of the endpoint registers
  vec_t end_a;
  vec_t end_b;

  projection_t pending_projections[$];
  int unsigned mismatches;
  int unsigned stalled_cycles;
  bit          quiet;   // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: exact integer arithmetic on wide intermediates.
  // --------------------------------------------------------------------------
  function automatic projection_t predict_projection(vec_t a, vec_t b, vec_t p);
    longint av[3], bv[3], pv[3], dv[3], nr[3];
    longint len2, dot, rem, e;
    longint unsigned t, dist2, root, bitv, n;
    region_t rg;
    projection_t res;
    av[0] = a.x; av[1] = a.y; av[2] = a.z;
    bv[0] = b.x; bv[1] = b.y; bv[2] = b.z;
    pv[0] = p.x; pv[1] = p.y; pv[2] = p.z;
    len2 = 0;
    dot  = 0;
    for (int i = 0; i < 3; i++) begin
      dv[i] = bv[i] - av[i];
      len2 += dv[i] * dv[i];
      dot  += dv[i] * (pv[i] - av[i]);
    end
    t = 0;
    if (len2 == 0 || dot <= 0) begin
      // zero-length segment or at/before A
      rg = RGN_AT_A;
      for (int i = 0; i < 3; i++) nr[i] = av[i];
    end else if (dot >= len2) begin
      rg = RGN_AT_B;
      t  = 64'd1 << FRAC_BITS;
      for (int i = 0; i < 3; i++) nr[i] = bv[i];
    end else begin
      // restoring division, one quotient bit at a time; dot*2^F would overflow
      rg  = RGN_INTERIOR;
      rem = dot;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem = rem <<< 1;
        t   = t << 1;
        if (rem >= len2) begin
          rem -= len2;
          t   |= 64'd1;
        end
      end
      for (int i = 0; i < 3; i++) begin
        nr[i] = av[i] + ((dv[i] * longint'(t)) >>> FRAC_BITS);   // floor
        if (nr[i] > 64'sd8388607)  nr[i] = 64'sd8388607;
        if (nr[i] < -64'sd8388608) nr[i] = -64'sd8388608;
      end
    end
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      e = pv[i] - nr[i];
      dist2 += longint'(e * e);
    end
    // truncated integer square root
    n    = dist2;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (root > 64'd33554431) root = 64'd33554431;
    res.near_x   = coord_t'(nr[0]);
    res.near_y   = coord_t'(nr[1]);
    res.near_z   = coord_t'(nr[2]);
    res.fraction = t[FRAC_BITS:0];
    res.region   = rg;
    res.distance = root[DIST_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the checker.
  // --------------------------------------------------------------------------
  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    projection_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_projections.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        mismatches++;
      end else begin
        want = pending_projections.pop_front();
        if (out_ch.near_x !== want.near_x) report_mismatch("near_x", out_ch.near_x, want.near_x);
        if (out_ch.near_y !== want.near_y) report_mismatch("near_y", out_ch.near_y, want.near_y);
        if (out_ch.near_z !== want.near_z) report_mismatch("near_z", out_ch.near_z, want.near_z);
        if (out_ch.fraction !== want.fraction)
          report_mismatch("fraction", out_ch.fraction, want.fraction);
        if (out_ch.region !== want.region) report_mismatch("region", out_ch.region, want.region);
        if (out_ch.distance !== want.distance)
          report_mismatch("distance", out_ch.distance, want.distance);
      end
    end
  end

  // watchdog: counts cycles in which no word moves on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_point(coord_t px, coord_t py, coord_t pz);
    vec_t p;
    if (!quiet && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    p = '{x: px, y: py, z: pz};
    in_ch.valid   <= 1'b1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.point_z <= pz;
    do @(posedge clk); while (!in_ch.ready);
    pending_projections.push_back(predict_projection(end_a, end_b, p));
  endtask

  // stop sending and wait until every outstanding word has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_projections.size() != 0) @(posedge clk);
  endtask

  // endpoints are only written with the pipeline empty
  task automatic set_segment(vec_t a, vec_t b);
    coord_t vals[6];
    drain_results();
    vals = '{a.x, a.y, a.z, b.x, b.y, b.z};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    end_a = a;
    end_b = b;
  endtask

  function automatic coord_t rand_coord(int unsigned span);
    if (span == 0) return coord_t'($urandom());
    return coord_t'(int'($urandom_range(2 * span)) - int'(span));
  endfunction

  // value near c, saturated to the coordinate range
  function automatic coord_t near_coord(coord_t c, int unsigned span);
    longint v;
    v = longint'(c) + longint'(int'($urandom_range(2 * span)) - int'(span));
    if (v > 64'sd8388607)  v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return coord_t'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  localparam coord_t CMAX = 24'sh7FFFFF;
  localparam coord_t CMIN = -24'sh800000;

  task automatic test_zero_length();
    // reset state: A = B = 0
    send_point(24'sd0, 24'sd0, 24'sd0);
    send_point(CMAX, CMIN, 24'sd256);
    set_segment('{x: 24'sd1000, y: -24'sd20, z: 24'sd7}, '{x: 24'sd1000, y: -24'sd20, z: 24'sd7});
    send_point(24'sd1000, -24'sd20, 24'sd7);
    send_point(CMIN, CMAX, CMIN);
  endtask

  task automatic test_clamp_regions();
    set_segment('{x: 24'sd0, y: 24'sd0, z: 24'sd0}, '{x: 24'sd2560, y: 24'sd0, z: 24'sd0});
    send_point(-24'sd1, 24'sd500, 24'sd0);     // before A
    send_point(24'sd0, 24'sd77, -24'sd3);      // exactly at A
    send_point(24'sd1280, 24'sd256, 24'sd256); // interior, half way
    send_point(24'sd2560, 24'sd10, 24'sd0);    // exactly at B
    send_point(24'sd9000, -24'sd9, 24'sd1);    // beyond B
    send_point(24'sd1, 24'sd0, 24'sd0);        // interior, small t
    // long segment: tiny positive dot truncates t to zero yet stays interior
    set_segment('{x: 24'sd0, y: 24'sd0, z: 24'sd0}, '{x: CMAX, y: CMAX, z: CMAX});
    send_point(24'sd1, 24'sd0, 24'sd0);
    send_point(24'sd4000000, -24'sd4000000, 24'sd123);
  endtask

  task automatic test_extremes();
    set_segment('{x: CMIN, y: CMIN, z: CMIN}, '{x: CMAX, y: CMAX, z: CMAX});
    send_point(CMAX, CMIN, CMAX);
    send_point(CMIN, CMAX, CMIN);
    send_point(CMAX, CMAX, CMAX);
    send_point(CMIN, CMIN, CMIN);
    // largest distance: degenerate segment in one corner, point in the other
    set_segment('{x: CMIN, y: CMIN, z: CMIN}, '{x: CMIN, y: CMIN, z: CMIN});
    send_point(CMAX, CMAX, CMAX);
    set_segment('{x: CMAX, y: CMIN, z: CMAX}, '{x: CMIN, y: CMAX, z: CMIN});
    send_point(CMAX, CMAX, CMIN);
    send_point(24'sd0, 24'sd0, 24'sd0);
  endtask

  task automatic test_random();
    vec_t a, b;
    int unsigned span, pspan;
    for (int phase = 0; phase < 8; phase++) begin
      // segment sizes: small, medium, full range
      span = (phase % 3 == 0) ? 4000 : (phase % 3 == 1) ? 200000 : 0;
      a = '{x: rand_coord(span), y: rand_coord(span), z: rand_coord(span)};
      b = '{x: rand_coord(span), y: rand_coord(span), z: rand_coord(span)};
      if (phase == 5) b = a;   // degenerate segment in the random mix
      set_segment(a, b);
      quiet = (phase == 3);
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(99) < 20) begin
          send_point(rand_coord(0), rand_coord(0), rand_coord(0));
        end else begin
          // around the segment, so all three regions turn up
          pspan = (span == 0) ? 4000000 : span * 2;
          send_point(near_coord(a.x + (b.x - a.x) / 2, pspan),
                     near_coord(a.y + (b.y - a.y) / 2, pspan),
                     near_coord(a.z + (b.z - a.z) / 2, pspan));
        end
        if (phase == 2 && k == 100) drain_results();   // pause until all back
      end
      quiet = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatches     = 0;
    stalled_cycles = 0;
    quiet          = 1'b0;
    end_a          = '0;
    end_b          = '0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.point_x  <= '0;
    in_ch.point_y  <= '0;
    in_ch.point_z  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_length();
    test_clamp_regions();
    test_extremes();
    test_random();

    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
